// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ais_pkg.sv =====
package ais_pkg;

    localparam int DATA_W = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } ais_ctrl_t;

endpackage

// ===== design/ais_cell.sv =====
module ais_cell (
    input  logic              clk,
    input  ais_pkg::ais_ctrl_t ctrl,
    input  ais_pkg::data_t    new_val,
    input  logic              occ,
    input  logic              left_lt,
    input  ais_pkg::data_t    left_val,
    input  ais_pkg::data_t    right_val,
    output ais_pkg::data_t    val,
    output logic              lt
);
    import ais_pkg::*;

    data_t val_reg;
    data_t val_next;

    // An empty cell counts as larger than any value; an insert always fills it.
    assign lt  = !occ || (new_val < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins && lt)
        begin
            val_next = left_lt ? left_val : new_val;
        end
        else if (ctrl.pop)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== design/ascending_integer_sorter.sv =====
// A set starts to drain in the cycle after its last input beat or the beat that fills the store.
// One input beat per cycle while loading, then one output beat per cycle while
// draining and drain_stall is low.
// The load side stalls while a set drains through the cell chain.
// Reset clears the element count and the drain flag; cell contents are not reset.
module ascending_integer_sorter #(
    parameter int MAX_ELEMENTS = ais_pkg::MAX_ELEMENTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load_valid,
    output logic           load_stall,
    input  ais_pkg::data_t value,
    input  logic           last_in,
    output logic           drain_valid,
    input  logic           drain_stall,
    output ais_pkg::data_t sorted_value,
    output logic           last_out
);
    import ais_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             drain_reg;
    logic             drain_next;
    logic             load_fire;
    logic             drain_fire;
    ais_ctrl_t        ctrl;

    data_t cell_val [MAX_ELEMENTS];
    logic  cell_lt  [MAX_ELEMENTS];

    assign load_fire  = load_valid && !drain_reg;
    assign drain_fire = drain_reg && !drain_stall;
    assign ctrl       = '{ins: load_fire, pop: drain_fire};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            ais_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .new_val   (value),
                .occ       (CNT_W'(gi) < count_reg),
                .left_lt   ((gi == 0) ? 1'b0 : cell_lt[(gi == 0) ? 0 : gi - 1]),
                .left_val  (cell_val[(gi == 0) ? 0 : gi - 1]),
                .right_val ((gi == MAX_ELEMENTS - 1) ? value
                            : cell_val[(gi == MAX_ELEMENTS - 1) ? gi : gi + 1]),
                .val       (cell_val[gi]),
                .lt        (cell_lt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        drain_next = drain_reg;
        if (load_fire)
        begin
            count_next = count_reg + CNT_W'(1);
            if (last_in || (count_reg == CNT_W'(MAX_ELEMENTS - 1)))
            begin
                drain_next = 1'b1;
            end
        end
        else if (drain_fire)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drain_reg <= drain_next;
        end
    end

    assign load_stall   = drain_reg;
    assign drain_valid  = drain_reg;
    assign sorted_value = cell_val[0];
    assign last_out     = (count_reg == CNT_W'(1));

endmodule

// ===== design/ais_checker.sv =====
`include "assert_macros.svh"

module ais_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           load_valid,
    input logic           load_stall,
    input ais_pkg::data_t value,
    input logic           last_in,
    input logic           drain_valid,
    input logic           drain_stall,
    input ais_pkg::data_t sorted_value,
    input logic           last_out
);
    import ais_pkg::*;

    // A waiting output beat stays offered.
    `ASSERT_NEXT(a_drain_holds, drain_valid && drain_stall, drain_valid, "output beat dropped")

    // The last input beat of a set starts the drain.
    `ASSERT_NEXT(a_last_drains, load_valid && !load_stall && last_in, drain_valid, "set not drained")

    // No input beat is taken while a set drains.
    `ASSERT_ALWAYS(a_no_load_in_drain, !drain_valid || load_stall, "load during drain")

    // Output beats within a set never decrease.
    `ASSERT_NEXT(a_ascending, drain_valid && !drain_stall && !last_out,
        !(sorted_value < $past(sorted_value)), "output out of order")

endmodule

bind ascending_integer_sorter ais_checker u_ais_checker (.*);

// ===== bench/ascending_integer_sorter_test.sv =====
module ascending_integer_sorter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ais_pkg::*;

    localparam int SET_CAPACITY = MAX_ELEMENTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 50;

    typedef struct {
        data_t value;
        logic  last;
    } sorted_beat_t;

    logic  clk;
    logic  rst_n;
    logic  load_valid;
    logic  load_stall;
    data_t value;
    logic  last_in;
    logic  drain_valid;
    logic  drain_stall;
    data_t sorted_value;
    logic  last_out;

    data_t        held_set[$];
    sorted_beat_t pending_beats[$];
    sorted_beat_t next_beat;

    int load_gap_max;
    int drain_gap_max;
    int error_count;
    int cycle_count;
    int items_sent;
    int sets_sorted;
    int beats_checked;

    ascending_integer_sorter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_stall   (load_stall),
        .value        (value),
        .last_in      (last_in),
        .drain_valid  (drain_valid),
        .drain_stall  (drain_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d beats outstanding",
                     cycle_count, pending_beats.size());
            $display("FAIL ascending_integer_sorter");
            $finish;
        end
    end

    // New values go after any equal values already held, so duplicates keep arrival order.
    function automatic void insert_and_flush(data_t v, logic last);
        int pos;
        sorted_beat_t beat;
        pos = held_set.size();
        while (pos > 0 && v < held_set[pos - 1])
            pos--;
        held_set.insert(pos, v);
        if (last || held_set.size() == SET_CAPACITY)
        begin
            foreach (held_set[k])
            begin
                beat.value = held_set[k];
                beat.last = (k == held_set.size() - 1);
                pending_beats.push_back(beat);
            end
            held_set.delete();
            sets_sorted++;
        end
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 7) - 4;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_gap_limit();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 17;
        endcase
    endfunction

    task automatic send_item(data_t v, logic last);
        int gap;
        @(negedge clk);
        gap = $urandom_range(0, load_gap_max);
        if (gap > 0)
        begin
            load_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        load_valid <= 1'b1;
        value <= v;
        last_in <= last;
        @(posedge clk);
        while (load_stall)
            @(posedge clk);
        insert_and_flush(v, last);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && drain_valid && !drain_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat value %0d last %0b",
                         $time, sorted_value, last_out);
            end
            else
            begin
                next_beat = pending_beats.pop_front();
                beats_checked++;
                if (sorted_value !== next_beat.value)
                begin
                    error_count++;
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, next_beat.value, sorted_value);
                end
                if (last_out !== next_beat.last)
                begin
                    error_count++;
                    $display("%0t: last_out expected %0b actual %0b",
                             $time, next_beat.last, last_out);
                end
            end
        end
    end

    initial
    begin : drain_pacing
        int hold;
        drain_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = $urandom_range(0, drain_gap_max);
            if (hold > 0)
            begin
                drain_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            drain_stall <= 1'b0;
            @(posedge clk);
            while (!drain_valid)
                @(posedge clk);
        end
    end

    task automatic test_extremes();
        load_gap_max = 0;
        drain_gap_max = 0;
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h8000_0001, 1'b0);
        send_item(32'h7fff_fffe, 1'b1);
    endtask

    task automatic test_single_element();
        load_gap_max = 3;
        drain_gap_max = 3;
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7fff_ffff, 1'b1);
    endtask

    task automatic test_duplicates();
        load_gap_max = 17;
        drain_gap_max = 17;
        send_item(5, 1'b0);
        send_item(-3, 1'b0);
        send_item(5, 1'b0);
        send_item(-3, 1'b0);
        send_item(5, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b1);
    endtask

    // The fill never raises last_in, so the filling beat has to end the set.
    task automatic test_store_fill();
        load_gap_max = 0;
        drain_gap_max = 17;
        for (int n = 0; n < SET_CAPACITY; n++)
            send_item(pick_value(), 1'b0);
    endtask

    task automatic test_random_sets();
        int start_count;
        int set_len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            load_gap_max = pick_gap_limit();
            drain_gap_max = pick_gap_limit();
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, SET_CAPACITY)
                                                  : $urandom_range(1, 12);
            for (int n = 0; n < set_len; n++)
                send_item(pick_value(), n == set_len - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        load_valid = 1'b0;
        value = '0;
        last_in = 1'b0;
        load_gap_max = 0;
        drain_gap_max = 0;
        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        sets_sorted = 0;
        beats_checked = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_single_element();
        test_duplicates();
        test_store_fill();
        test_random_sets();

        @(negedge clk);
        load_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (2 * SET_CAPACITY) @(posedge clk);

        $display("Sorted %0d sets from %0d input beats, %0d output beats checked,",
                 sets_sorted, items_sent, beats_checked);
        $display("including extreme values, duplicates, single elements and full stores.");
        if (error_count == 0)
            $display("PASS ascending_integer_sorter");
        else
            $display("FAIL ascending_integer_sorter");
        $finish;
    end

endmodule
